FILE: hw/rtl/avbt_pkg.sv
`timescale 1ns / 1ps

package avbt_pkg;

    typedef enum logic [1:0] {
        OP_VOLUME  = 2'd0,
        OP_BASS    = 2'd1,
        OP_TREBLE  = 2'd2,
        OP_BALANCE = 2'd3
    } op_t;

    localparam logic [2:0] SA_NONE  = 3'd0;
    localparam logic [2:0] SA_LEFT  = 3'd3;
    localparam logic [2:0] SA_RIGHT = 3'd4;
    localparam logic [2:0] SA_TONE  = 3'd5;

    localparam logic signed [7:0] VOL_MIN  = -8'sd87;
    localparam logic signed [7:0] VOL_MAX  = 8'sd14;
    localparam logic signed [7:0] TONE_MIN = -8'sd14;
    localparam logic signed [7:0] TONE_MAX = 8'sd14;
    localparam logic signed [7:0] BAL_MIN  = -8'sd50;
    localparam logic signed [7:0] BAL_MAX  = 8'sd50;
    localparam logic [6:0]        VOL_SPAN = 7'd87;
    localparam logic signed [8:0] LVL_MIN  = -9'sd87;

    // floor(x / 50) == (x * 1311) >> 16 for x <= 50 * 87
    localparam logic [10:0] RECIP_50    = 11'd1311;
    localparam int          RECIP_SHIFT = 16;

    localparam logic [3:0] FINE8_MAX = 4'b1000 - 4'd1;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                is_vol;
        logic                wr;
        logic [2:0]          sub_addr;
        logic [7:0]          data;
        logic                changed;
        logic signed [7:0]   vol;
        logic                bal_neg;
        logic [12:0]         prod;     // |balance| * (87 - |volume|)
    } entry_t;

    function automatic logic [3:0] tone_nibble(input logic signed [4:0] x);
        logic [4:0] mag;
        logic [2:0] step;
        begin
            mag  = x[4] ? 5'(-x) : 5'(x);
            step = 3'd7 - mag[3:1];
            tone_nibble = {(!x[4] && (x != 5'sd0)), step};
        end
    endfunction

    function automatic logic [7:0] level_byte(input logic signed [8:0] lvl);
        logic [8:0] a;
        logic [3:0] eights;
        logic [2:0] fine8;
        logic [3:0] extra8;
        begin
            a      = 9'(-lvl);
            eights = a[6:3];
            fine8  = (eights > FINE8_MAX) ? FINE8_MAX[2:0] : eights[2:0];
            extra8 = eights - {1'b0, fine8};
            if (!lvl[8])
                level_byte = 8'd0;
            else
                level_byte = {extra8[1:0], fine8, a[2:0]};
        end
    endfunction

endpackage

FILE: hw/rtl/avbt_front.sv
`timescale 1ns / 1ps

module avbt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           opcode,
    input  logic signed [7:0]    value,
    input  logic                 q_full,
    output logic                 push,
    output avbt_pkg::entry_t     push_entry
);

    logic signed [4:0] bass_reg, bass_next;
    logic signed [4:0] treble_reg, treble_next;
    logic signed [6:0] bal_reg, bal_next;

    logic              accept;
    logic signed [7:0] vol_c;
    logic [7:0]        vol_abs8;
    logic [6:0]        vol_rem;
    logic [6:0]        bal_abs7;
    logic signed [4:0] tone_c;
    logic signed [6:0] bal_c;
    logic              tone_same;
    logic signed [4:0] bass_new, treble_new;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept;

    always_comb
    begin
        if (value < avbt_pkg::VOL_MIN)
            vol_c = avbt_pkg::VOL_MIN;
        else if (value > avbt_pkg::VOL_MAX)
            vol_c = avbt_pkg::VOL_MAX;
        else
            vol_c = value;

        if (value < avbt_pkg::TONE_MIN)
            tone_c = 5'(avbt_pkg::TONE_MIN);
        else if (value > avbt_pkg::TONE_MAX)
            tone_c = 5'(avbt_pkg::TONE_MAX);
        else
            tone_c = value[4:0];

        if (value < avbt_pkg::BAL_MIN)
            bal_c = 7'(avbt_pkg::BAL_MIN);
        else if (value > avbt_pkg::BAL_MAX)
            bal_c = 7'(avbt_pkg::BAL_MAX);
        else
            bal_c = value[6:0];
    end

    assign vol_abs8 = vol_c[7] ? 8'(-vol_c) : 8'(vol_c);
    assign vol_rem  = avbt_pkg::VOL_SPAN - vol_abs8[6:0];
    assign bal_abs7 = bal_reg[6] ? 7'(-bal_reg) : 7'(bal_reg);

    always_comb
    begin
        bass_new   = bass_reg;
        treble_new = treble_reg;
        tone_same  = 1'b0;
        bal_next   = bal_reg;

        push_entry          = '0;
        push_entry.vol      = vol_c;
        push_entry.bal_neg  = bal_reg[6];
        push_entry.prod     = {7'd0, bal_abs7[5:0]} * {6'd0, vol_rem};

        unique case (avbt_pkg::op_t'(opcode))
            avbt_pkg::OP_VOLUME:
            begin
                push_entry.is_vol = 1'b1;
                push_entry.wr     = 1'b1;
            end
            avbt_pkg::OP_BASS, avbt_pkg::OP_TREBLE:
            begin
                if (avbt_pkg::op_t'(opcode) == avbt_pkg::OP_BASS)
                begin
                    tone_same = (bass_reg == tone_c);
                    bass_new  = tone_c;
                end
                else
                begin
                    tone_same  = (treble_reg == tone_c);
                    treble_new = tone_c;
                end
                if (!tone_same)
                begin
                    push_entry.wr       = 1'b1;
                    push_entry.sub_addr = avbt_pkg::SA_TONE;
                    push_entry.data     = {avbt_pkg::tone_nibble(bass_new),
                                           avbt_pkg::tone_nibble(treble_new)};
                end
            end
            avbt_pkg::OP_BALANCE:
            begin
                push_entry.changed = (bal_reg != bal_c);
                bal_next           = bal_c;
            end
            default:
            begin
                push_entry.is_vol = 1'b0;
            end
        endcase

        push_entry.sub_addr = push_entry.is_vol ? avbt_pkg::SA_NONE : push_entry.sub_addr;
    end

    assign bass_next   = accept ? bass_new   : bass_reg;
    assign treble_next = accept ? treble_new : treble_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bass_reg   <= '0;
            treble_reg <= '0;
            bal_reg    <= '0;
        end
        else
        begin
            bass_reg   <= bass_next;
            treble_reg <= treble_next;
            if (accept)
                bal_reg <= bal_next;
        end
    end

endmodule

FILE: hw/rtl/avbt_queue.sv
`timescale 1ns / 1ps

module avbt_queue #(
    parameter int DEPTH = avbt_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  avbt_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output avbt_pkg::entry_t  head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    avbt_pkg::entry_t mem_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/avbt_back.sv
`timescale 1ns / 1ps

module avbt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  avbt_pkg::entry_t  head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_wr,
    output logic [2:0]        out_sub_addr,
    output logic [7:0]        out_data,
    output logic              out_changed,
    output logic              out_last
);

    logic       out_valid_reg, out_valid_next;
    logic       phase_reg, phase_next;     // 0: left write, 1: right write
    logic       wr_reg;
    logic [2:0] sub_addr_reg;
    logic [7:0] data_reg;
    logic       changed_reg;
    logic       last_reg;

    logic              load;
    logic [23:0]       scaled;
    logic [6:0]        att;
    logic              atten;
    logic signed [8:0] diff;
    logic signed [8:0] lvl;

    logic       wr_next;
    logic [2:0] sub_addr_next;
    logic [7:0] data_next;
    logic       changed_next;
    logic       last_next;

    assign load = head_valid && (!out_valid_reg || out_ready);

    assign scaled = {11'd0, head.prod} * {13'd0, avbt_pkg::RECIP_50};
    assign att    = scaled[avbt_pkg::RECIP_SHIFT +: 7];
    // balance below zero pulls down the left channel, otherwise the right
    assign atten  = head.bal_neg ^ phase_reg;
    assign diff   = {head.vol[7], head.vol} - {2'b00, att};

    always_comb
    begin
        if (!atten)
            lvl = {head.vol[7], head.vol};
        else if (diff < avbt_pkg::LVL_MIN)
            lvl = avbt_pkg::LVL_MIN;
        else
            lvl = diff;
    end

    always_comb
    begin
        wr_next       = head.wr;
        sub_addr_next = head.sub_addr;
        data_next     = head.data;
        changed_next  = head.changed;
        last_next     = 1'b1;
        phase_next    = phase_reg;
        pop           = load;
        if (head.is_vol)
        begin
            data_next     = avbt_pkg::level_byte(lvl);
            sub_addr_next = phase_reg ? avbt_pkg::SA_RIGHT : avbt_pkg::SA_LEFT;
            last_next     = phase_reg;
            pop           = load && phase_reg;
            if (load)
                phase_next = !phase_reg;
        end
    end

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            wr_reg       <= wr_next;
            sub_addr_reg <= sub_addr_next;
            data_reg     <= data_next;
            changed_reg  <= changed_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_wr       = wr_reg;
    assign out_sub_addr = sub_addr_reg;
    assign out_data     = data_reg;
    assign out_changed  = changed_reg;
    assign out_last     = last_reg;

endmodule

FILE: hw/rtl/audio_volume_balance_tone_encoder.sv
`timescale 1ns / 1ps

// Audio control command encoder: turns volume, bass, treble and balance
// commands into register writes for an audio processor.
// Input stream: tuser carries the opcode (0 volume, 1 bass, 2 treble,
// 3 balance), tdata the signed value. Output stream: tuser is high when the
// item is a register write, tdata holds sub-address, data byte and the
// balance changed flag, tlast marks the final item of a command.
// A volume command gives two items (left then right volume); every other
// command gives one. The first item passes through the queue and then the
// output register before it shows on the output. Throughput: one command
// per cycle for bass, treble and balance while the receiver is ready; a volume
// command fills the output register twice, once per channel.
// Commands go into a short queue (QUEUE_DEPTH items) that the front fills
// and the back drains, so the input keeps taking items while a result waits.
// When the receiver stalls, the output item holds and the queue fills;
// tready drops only with the queue full.
// Reset clears the stored bass, treble and balance levels to zero and
// empties the queue and the output register.
module audio_volume_balance_tone_encoder #(
    parameter int QUEUE_DEPTH = avbt_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] sub_address, [10:3] data, [11] changed
    output logic [0:0]  m_axis_tuser,   // [0] write_valid
    output logic        m_axis_tlast
);

    logic             push;
    logic             q_full;
    logic             pop;
    logic             head_valid;
    avbt_pkg::entry_t push_entry;
    avbt_pkg::entry_t head;

    logic       out_wr;
    logic [2:0] out_sub_addr;
    logic [7:0] out_data;
    logic       out_changed;

    avbt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .opcode     (s_axis_tuser),
        .value      (s_axis_tdata),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    avbt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (head_valid),
        .head       (head)
    );

    avbt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_wr       (out_wr),
        .out_sub_addr (out_sub_addr),
        .out_data     (out_data),
        .out_changed  (out_changed),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, out_changed, out_data, out_sub_addr};
    assign m_axis_tuser = out_wr;

    // left volume write is never the last item of its command
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0] && (out_sub_addr == avbt_pkg::SA_LEFT))
        |-> !m_axis_tlast)
        else $error("left volume write marked last");

    // items that are not writes end their command
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && (out_data == 8'd0)))
        else $error("non-write item malformed");

    // writes only go to the volume and tone registers
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        ((out_sub_addr == avbt_pkg::SA_LEFT) || (out_sub_addr == avbt_pkg::SA_RIGHT) ||
         (out_sub_addr == avbt_pkg::SA_TONE)) && !out_changed)
        else $error("write to unexpected sub-address");

endmodule
